@@ design/ahfr_pkg.sv @@
// Shared types, field widths and codes of the additive harmonic frame renderer
`timescale 1ns / 1ps

package ahfr_pkg;

    // field widths
    localparam int KIND_W     = 2;
    localparam int HIDX_W     = 8;
    localparam int COEF_W     = 16;
    localparam int POS_W      = 11;
    localparam int SAMPLE_W   = 24;
    localparam int PEAK_W     = 23;
    localparam int FSL_W      = 4;
    localparam int MAXH_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // transaction kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HARMONICS   = 1'b1;
    localparam logic [FSL_W-1:0]     FSL_RESET           = 4'd11;
    localparam logic [MAXH_W-1:0]    MAXH_RESET          = 9'd256;

    // fixed point output conversion
    localparam int SAMPLE_MAX = 8388607;
    localparam int ROUND_HALF = 16384;
    localparam int FRAC_SHIFT = 15;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [HIDX_W-1:0]        harmonic_index;
        logic signed [COEF_W-1:0] sine_coef;
        logic signed [COEF_W-1:0] cosine_coef;
        logic [POS_W-1:0]         sample_index;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [PEAK_W-1:0]          peak;
        logic                       saturated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_ROUND,
        ST_FINISH
    } ahfr_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_we;
        logic peak_clear;
        logic clear_step;
        logic sample_start;
        logic mod_step;
        logic run_start;
        logic run_issue;
        logic round_en;
        logic load_out;
    } ahfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic mod_last;
        logic run_empty;
        logic run_last;
        logic pipe_busy;
        logic out_free;
    } ahfr_status_t;

endpackage

@@ design/ahfr_sine_rom.sv @@
// Full-period sine table, Q1.15, with a registered read port
`timescale 1ns / 1ps

module ahfr_sine_rom #(
    parameter int TABLE_SIZE = 2048
) (
    input  logic                             aclk,
    input  logic                             rd_en,
    input  logic [$clog2(TABLE_SIZE)-1:0]    rd_addr,
    output logic signed [15:0]               rd_data
);

    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    typedef logic signed [15:0] rom_table_t [TABLE_SIZE];

    // one entry: angle in q30, folded to the first quadrant, taylor series to x^13
    function automatic logic signed [15:0] sine_entry(input logic [63:0] n);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] mag;
        logic        neg;
        x   = (n * TWO_PI_Q30) / TABLE_SIZE;
        neg = 1'b0;
        if (x > PI_Q30) begin
            x   = x - PI_Q30;
            neg = 1'b1;
        end
        if (x > HALF_PI_Q30) begin
            x = PI_Q30 - x;
        end
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int j = 1; j <= 6; j++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[j];
            if ((j % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        mag = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return neg ? -16'(mag) : 16'(mag);
    endfunction

    function automatic rom_table_t build_table();
        rom_table_t tbl;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            tbl[i] = sine_entry(64'(i));
        end
        return tbl;
    endfunction

    localparam rom_table_t SINE_TABLE = build_table();

    logic signed [15:0] rd_data_reg;

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= SINE_TABLE[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/ahfr_datapath.sv @@
// Datapath: coefficient store, phase unit, multiply-accumulate, rounding and output register
`timescale 1ns / 1ps

module ahfr_datapath #(
    parameter int TABLE_SIZE         = 2048,
    parameter int MAX_HARMONIC_COUNT = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ahfr_pkg::ahfr_cmd_t          cmd,
    output ahfr_pkg::ahfr_status_t       status,
    input  ahfr_pkg::in_item_t           s_data,
    input  logic [ahfr_pkg::FSL_W-1:0]   cfg_frame_size_log2,
    input  logic [ahfr_pkg::MAXH_W-1:0]  cfg_max_harmonics,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ahfr_pkg::out_item_t          m_data
);

    import ahfr_pkg::*;

    localparam int AW      = $clog2(TABLE_SIZE);
    localparam int HA_W    = (MAX_HARMONIC_COUNT > 1) ? $clog2(MAX_HARMONIC_COUNT) : 1;
    localparam int LIM_W   = $clog2(MAX_HARMONIC_COUNT + 1);
    localparam int TC_W    = $clog2(2 * MAX_HARMONIC_COUNT);
    localparam int BP_W    = $clog2(POS_W);
    localparam int ACC_W   = 2 * COEF_W + TC_W + 1;
    localparam int QW      = ACC_W + 1 - FRAC_SHIFT;
    localparam int CMP_W   = (QW > SAMPLE_W + 1) ? QW : SAMPLE_W + 1;
    localparam int QUARTER = TABLE_SIZE / 4;

    localparam logic [AW:0]                T_EXT     = (AW + 1)'(TABLE_SIZE);
    localparam logic [AW:0]                Q_EXT     = (AW + 1)'(QUARTER);
    localparam logic signed [CMP_W-1:0]    SAT_MAX   = CMP_W'(SAMPLE_MAX);
    localparam logic signed [CMP_W-1:0]    SAT_MIN   = -SAT_MAX;
    localparam logic [HA_W-1:0]            LAST_ADDR = HA_W'(MAX_HARMONIC_COUNT - 1);

    // coefficient store: cosine in the upper half, sine in the lower half
    logic [2*COEF_W-1:0] store [MAX_HARMONIC_COUNT];

    logic [HA_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]         pos_reg;
    logic [AW:0]              step_reg;
    logic [LIM_W-1:0]         limit_reg, limit_next;
    logic [AW-1:0]            d_reg, d_next;
    logic [BP_W-1:0]          bit_ptr_reg;
    logic [AW-1:0]            ph_reg, ph_next;
    logic [TC_W-1:0]          term_reg;
    logic                     v1_reg, v2_reg;
    logic                     sel1_reg;
    logic [2*COEF_W-1:0]      word1_reg;
    logic signed [2*COEF_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [QW-1:0]     q_reg, q_next;
    logic [PEAK_W-1:0]        peak_reg, peak_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg;

    logic                     load_hit;
    logic [AW:0]              d_dbl, d_dbl_mod, d_add;
    logic [AW:0]              ph_add, cos_add;
    logic [AW-1:0]            cos_ph;
    logic [AW-1:0]            rom_addr;
    logic signed [15:0]       rom_q;
    logic [HA_W-1:0]          rd_addr;
    logic                     issue_sel;
    logic [TC_W-1:0]          last_term;
    logic signed [COEF_W-1:0] coef1;
    logic signed [ACC_W:0]    round_sum;
    logic signed [CMP_W-1:0]  q_ext;
    logic signed [SAMPLE_W-1:0] sample_val;
    logic [SAMPLE_W-1:0]      mag_full;
    logic [PEAK_W-1:0]        mag;
    logic                     sat;

    // store write port: clearing pass or load
    assign load_hit = cmd.load_we && (32'(s_data.harmonic_index) < MAX_HARMONIC_COUNT);

    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            store[clr_cnt_reg] <= '0;
        end else if (load_hit) begin
            store[HA_W'(s_data.harmonic_index)] <= {s_data.cosine_coef, s_data.sine_coef};
        end
    end

    // store read port
    assign rd_addr = HA_W'(term_reg >> 1);

    always_ff @(posedge aclk) begin
        if (cmd.run_issue) begin
            word1_reg <= store[rd_addr];
        end
    end

    // clear sweep counter
    assign clr_cnt_next = (clr_cnt_reg == LAST_ADDR) ? '0 : clr_cnt_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // bit-serial reduction of sample_index * step modulo the table size
    always_comb begin
        d_dbl     = {d_reg, 1'b0};
        d_dbl_mod = (d_dbl >= T_EXT) ? d_dbl - T_EXT : d_dbl;
        d_add     = d_dbl_mod + (pos_reg[bit_ptr_reg] ? step_reg : '0);
        d_next    = AW'((d_add >= T_EXT) ? d_add - T_EXT : d_add);
    end

    // band limit capped to the store depth
    assign limit_next = (32'(cfg_max_harmonics) > MAX_HARMONIC_COUNT)
                        ? LIM_W'(MAX_HARMONIC_COUNT) : LIM_W'(cfg_max_harmonics);

    always_ff @(posedge aclk) begin
        if (cmd.sample_start) begin
            pos_reg     <= s_data.sample_index;
            step_reg    <= T_EXT >> cfg_frame_size_log2;
            limit_reg   <= limit_next;
            d_reg       <= '0;
            bit_ptr_reg <= BP_W'(POS_W - 1);
        end else if (cmd.mod_step) begin
            d_reg       <= d_next;
            bit_ptr_reg <= bit_ptr_reg - 1'b1;
        end
    end

    // phase walk over harmonics, two terms per harmonic
    always_comb begin
        issue_sel = term_reg[0];
        cos_add   = {1'b0, ph_reg} + Q_EXT;
        cos_ph    = AW'((cos_add >= T_EXT) ? cos_add - T_EXT : cos_add);
        ph_add    = {1'b0, ph_reg} + {1'b0, d_reg};
        ph_next   = AW'((ph_add >= T_EXT) ? ph_add - T_EXT : ph_add);
        rom_addr  = issue_sel ? cos_ph : ph_reg;
        last_term = TC_W'({limit_reg, 1'b0} - (LIM_W + 1)'(1));
    end

    always_ff @(posedge aclk) begin
        if (cmd.run_start) begin
            ph_reg   <= d_reg;
            term_reg <= '0;
        end else if (cmd.run_issue) begin
            term_reg <= term_reg + 1'b1;
            if (issue_sel) begin
                ph_reg <= ph_next;
            end
        end
    end

    ahfr_sine_rom #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (cmd.run_issue),
        .rd_addr (rom_addr),
        .rd_data (rom_q)
    );

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.run_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.run_issue) begin
            sel1_reg <= issue_sel;
        end
    end

    // multiply, then accumulate
    assign coef1     = sel1_reg ? $signed(word1_reg[2*COEF_W-1:COEF_W])
                                : $signed(word1_reg[COEF_W-1:0]);
    assign prod_next = coef1 * rom_q;

    always_comb begin
        acc_next = acc_reg;
        if (cmd.sample_start) begin
            acc_next = '0;
        end else if (v2_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    // round half up to an integer, q.0, dropping the 15 fraction bits
    always_comb begin
        round_sum = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(ROUND_HALF);
        q_next    = QW'(round_sum >>> FRAC_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (cmd.round_en) begin
            q_reg <= q_next;
        end
    end

    // saturation, magnitude and peak
    always_comb begin
        q_ext = CMP_W'(q_reg);
        sat   = 1'b0;
        if (q_ext > SAT_MAX) begin
            sample_val = SAMPLE_W'(SAT_MAX);
            sat        = 1'b1;
        end else if (q_ext < SAT_MIN) begin
            sample_val = SAMPLE_W'(SAT_MIN);
            sat        = 1'b1;
        end else begin
            sample_val = SAMPLE_W'(q_ext);
        end
        mag_full  = (sample_val < 0) ? SAMPLE_W'(-sample_val) : SAMPLE_W'(sample_val);
        mag       = mag_full[PEAK_W-1:0];
        peak_next = (mag > peak_reg) ? mag : peak_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= '0;
        end else if (cmd.peak_clear) begin
            peak_reg <= '0;
        end else if (cmd.load_out) begin
            peak_reg <= peak_next;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.sample    <= sample_val;
            m_data_reg.peak      <= peak_next;
            m_data_reg.saturated <= sat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // status to the controller
    always_comb begin
        status.clear_last = (clr_cnt_reg == LAST_ADDR);
        status.mod_last   = (bit_ptr_reg == '0);
        status.run_empty  = (limit_reg == '0);
        status.run_last   = (term_reg == last_term);
        status.pipe_busy  = v1_reg | v2_reg;
        status.out_free   = !m_valid_reg || m_ready;
    end

endmodule

@@ design/ahfr_controller.sv @@
// Controller: sequences clearing, loads and sample requests
`timescale 1ns / 1ps

module ahfr_controller (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ahfr_pkg::KIND_W-1:0]  s_kind,
    output ahfr_pkg::ahfr_cmd_t          cmd,
    input  ahfr_pkg::ahfr_status_t       status
);

    import ahfr_pkg::*;

    ahfr_state_t state_reg, state_next;

    // state register, reset starts the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_kind)
                        KIND_SAMPLE: state_next = ST_MOD;
                        KIND_CLEAR:  state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MOD: begin
                if (status.mod_last) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = status.run_empty ? ST_DRAIN : ST_RUN;
            end
            ST_RUN: begin
                if (status.run_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_kind)
                        KIND_LOAD:   cmd.load_we      = 1'b1;
                        KIND_SAMPLE: cmd.sample_start = 1'b1;
                        KIND_CLEAR:  cmd.peak_clear   = 1'b1;
                        default:     cmd              = '0;
                    endcase
                end
            end
            ST_MOD:    cmd.mod_step  = 1'b1;
            ST_SETUP:  cmd.run_start = 1'b1;
            ST_RUN:    cmd.run_issue = 1'b1;
            ST_DRAIN:  cmd           = '0;
            ST_ROUND:  cmd.round_en  = 1'b1;
            ST_FINISH: cmd.load_out  = status.out_free;
            default:   cmd           = '0;
        endcase
    end

endmodule

@@ design/additive_harmonic_frame_renderer_unit.sv @@
// Top level of the additive harmonic frame renderer
//
// Renders one band-limited wavetable sample per request as the sum of the stored
// harmonics' sine and cosine terms, read from one sine table (cosine at a quarter
// offset), in a single multiply-accumulate unit that takes one term per cycle. For a
// sample request, with L = min(max_harmonics, MAX_HARMONIC_COUNT), the phase
// increment is first reduced bit-serially, then 2*L terms feed the multiplier, then
// the pipeline drains and the sum is rounded and saturated, and it is loaded into
// the result register once the previous result has left the output; the next
// transaction is taken after that. A load writes the store as it is accepted.
// A clear zeroes the peak and the store in a pass over all MAX_HARMONIC_COUNT
// entries; the same pass runs after reset, and no transaction is accepted during it
// (configuration writes are taken at any time). The result register lets the next
// transaction be accepted while a result still waits on the output.
`timescale 1ns / 1ps

module additive_harmonic_frame_renderer_unit #(
    parameter int TABLE_SIZE         = 2048,
    parameter int MAX_HARMONIC_COUNT = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ahfr_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ahfr_pkg::out_item_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic [ahfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ahfr_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    import ahfr_pkg::*;

    logic [FSL_W-1:0]  fsl_reg;
    logic [MAXH_W-1:0] maxh_reg;
    ahfr_cmd_t         cmd;
    ahfr_status_t      status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsl_reg  <= FSL_RESET;
            maxh_reg <= MAXH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_SIZE_LOG2: fsl_reg  <= cfg_wr_data[FSL_W-1:0];
                CFG_MAX_HARMONICS:   maxh_reg <= cfg_wr_data[MAXH_W-1:0];
            endcase
        end
    end

    ahfr_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_data.kind),
        .cmd     (cmd),
        .status  (status)
    );

    ahfr_datapath #(
        .TABLE_SIZE         (TABLE_SIZE),
        .MAX_HARMONIC_COUNT (MAX_HARMONIC_COUNT)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .s_data              (s_data),
        .cfg_frame_size_log2 (fsl_reg),
        .cfg_max_harmonics   (maxh_reg),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_data              (m_data)
    );

endmodule

@@ design/ahfr_checker.sv @@
// Port-level checker of the frame renderer and its bind to the top level
`timescale 1ns / 1ps

module ahfr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input ahfr_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input ahfr_pkg::out_item_t m_data
);

    import ahfr_pkg::*;

    logic [SAMPLE_W-1:0] sample_mag;

    // magnitude of the shown sample
    assign sample_mag = (m_data.sample < 0) ? SAMPLE_W'(-m_data.sample)
                                            : SAMPLE_W'(m_data.sample);

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transaction changed while stalled");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // the clearing pass blocks input right after reset
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_ready && !m_valid)
        else $error("block ready before the clearing pass");

    // the peak covers the sample it comes with
    a_peak_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.peak} >= sample_mag))
        else $error("peak below the sample magnitude");

    // a clipped sample sits at full scale
    a_sat_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.sample == SAMPLE_W'(SAMPLE_MAX)) || (m_data.sample == SAMPLE_W'(-SAMPLE_MAX)))
        else $error("saturated flag without a full-scale sample");

endmodule

bind additive_harmonic_frame_renderer_unit ahfr_checker u_checker (.*);
